FILE: rtl/core/fds_pkg.sv
// Shared types, sizes and key conversion helpers for the face depth sorter.
package fds_pkg;

  localparam int unsigned MAX_FACES = 64;
  localparam int unsigned KEY_BITS  = 32;
  localparam int unsigned CNT_W     = $clog2(MAX_FACES + 1);

  typedef logic signed [KEY_BITS-1:0] key_t;
  typedef logic [CNT_W-1:0]           count_t;

  // One buffered face: handle and depth key.
  typedef struct packed {
    logic [15:0] face_ref;
    key_t        key;
  } rec_t;

  // Chain-wide control, the same for every cell.
  typedef struct packed {
    logic insert;  // store the incoming face in sorted place
    logic shift;   // move every record one cell toward the head
  } chain_ctrl_t;

  // Bring a 32-bit depth to key width: sign-extend, then truncate.
  function automatic key_t to_key(input logic signed [31:0] depth);
    logic signed [63:0] wide;
    wide = 64'(depth);
    return key_t'(wide[KEY_BITS-1:0]);
  endfunction

  // Bring a key back to a 32-bit depth: sign-extend, keep the low bits.
  function automatic logic signed [31:0] to_depth(input key_t key);
    logic signed [63:0] wide;
    wide = 64'(key);
    return wide[31:0];
  endfunction

endpackage

FILE: rtl/core/fds_cell.sv
// One cell of the insertion chain: holds a record and trades it with its neighbors.
module fds_cell
  import fds_pkg::*;
(
  input  logic        clk_i,
  input  chain_ctrl_t ctrl_i,
  input  logic        occupied_i,   // this cell holds a buffered face
  input  rec_t        new_rec_i,    // incoming face, sent to every cell
  input  rec_t        prev_rec_i,   // record of the cell toward the head
  input  logic        prev_ins_i,   // incoming face lands at or before the previous cell
  input  rec_t        next_rec_i,   // record of the cell toward the tail
  output rec_t        rec_o,
  output logic        ins_o         // incoming face lands at or before this cell
);

  rec_t rec_q, rec_d;

  // Land the new face ahead of every strictly nearer face; equal keys keep order.
  assign ins_o = !occupied_i || (rec_q.key < new_rec_i.key);

  // Pick the next content: insert-and-push, shift toward the head, or hold.
  always_comb begin
    rec_d = rec_q;
    if (ctrl_i.shift) begin
      rec_d = next_rec_i;
    end else if (ctrl_i.insert && ins_o) begin
      rec_d = prev_ins_i ? prev_rec_i : new_rec_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

FILE: rtl/core/face_depth_sorter.sv
// Top level of the face depth sorter: cell chain, fill count and frame drain control.
//
// Faces are accepted one per cycle into a chain of MAX_FACES cells that keeps
// them sorted farthest first as they arrive, so collection runs at one face
// per cycle. A face carrying last_face closes the frame: from the next cycle
// the head cell is presented on the output and the chain shifts one place per
// accepted result until the frame has drained; no face is accepted while it
// drains. Equal depths come out in arrival order. Faces arriving with the
// chain full are dropped and every result of that frame carries overflowed.
// There is no clearing pass after reset.
module face_depth_sorter
  import fds_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        face_ref_i,
  input  logic signed [31:0] depth_key_i,
  input  logic               last_face_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        sorted_ref_o,
  output logic signed [31:0] sorted_depth_o,
  output logic               end_of_list_o,
  output logic               overflowed_o
);

  count_t      count_q, count_d;
  logic        drain_q, drain_d;
  logic        drop_q, drop_d;
  logic        in_acc, out_acc, full, last_out;
  chain_ctrl_t ctrl;
  rec_t        new_rec;
  rec_t        rec   [MAX_FACES];
  logic        ins   [MAX_FACES];

  assign in_ready_o  = !drain_q;
  assign out_valid_o = drain_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;
  assign full        = (count_q == count_t'(MAX_FACES));
  assign last_out    = (count_q == count_t'(1));

  assign ctrl.insert = in_acc && !full;
  assign ctrl.shift  = out_acc;

  assign new_rec.face_ref = face_ref_i;
  assign new_rec.key      = to_key(depth_key_i);

  // Build the chain: head cell at index zero holds the farthest face.
  for (genvar i = 0; i < MAX_FACES; i++) begin : g_cell
    rec_t prev_rec, next_rec;
    logic prev_ins;

    if (i == 0) begin : g_head
      assign prev_rec = new_rec;
      assign prev_ins = 1'b0;
    end else begin : g_body
      assign prev_rec = rec[i-1];
      assign prev_ins = ins[i-1];
    end

    if (i == MAX_FACES - 1) begin : g_tail
      assign next_rec = rec[i];
    end else begin : g_mid
      assign next_rec = rec[i+1];
    end

    fds_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occupied_i (count_t'(i) < count_q),
      .new_rec_i  (new_rec),
      .prev_rec_i (prev_rec),
      .prev_ins_i (prev_ins),
      .next_rec_i (next_rec),
      .rec_o      (rec[i]),
      .ins_o      (ins[i])
    );
  end

  // Advance fill count, drop flag and drain flag.
  always_comb begin
    count_d = count_q;
    drain_d = drain_q;
    drop_d  = drop_q;
    if (ctrl.insert) begin
      count_d = count_q + count_t'(1);
    end
    if (in_acc && full) begin
      drop_d = 1'b1;
    end
    if (in_acc && last_face_i) begin
      drain_d = 1'b1;
    end
    if (out_acc) begin
      count_d = count_q - count_t'(1);
      if (last_out) begin
        drain_d = 1'b0;
        drop_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drain_q <= 1'b0;
      drop_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      drain_q <= drain_d;
      drop_q  <= drop_d;
    end
  end

  // Present the head cell.
  assign sorted_ref_o   = rec[0].face_ref;
  assign sorted_depth_o = to_depth(rec[0].key);
  assign end_of_list_o  = last_out;
  assign overflowed_o   = drop_q;

  // Draining always has at least one face to emit.
  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> count_q != '0)
    else $error("drain with empty chain");

  // Fill count never exceeds the chain length.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= count_t'(MAX_FACES))
    else $error("fill count beyond capacity");

  // Head two cells stay in descending order while draining.
  a_head_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drain_q && count_q >= count_t'(2)) |-> !(rec[0].key < rec[1].key))
    else $error("chain out of order");

  // An accepted face with room grows the count by one.
  a_count_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.insert |=> count_q == $past(count_q) + count_t'(1))
    else $error("fill count did not advance");

endmodule

FILE: test/tb_face_depth_sorter.sv
// Self-checking testbench for the face depth sorter: frames of faces in, sorted drain out.
`timescale 1ns / 1ps

module tb_face_depth_sorter;
  import fds_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned HOLD_CYCLES = 300;

  // Expected drain order for each frame, built as requests are accepted.
  class depth_order_board;
    typedef struct {
      logic [15:0]        face_ref;
      logic signed [31:0] depth;
      logic               eol;
      logic               ovf;
    } drain_rec_t;

    logic [15:0]  ref_buf [MAX_FACES];
    key_t         key_buf [MAX_FACES];
    int unsigned  fill;
    bit           dropped;
    drain_rec_t   drain_q [$];
    int unsigned  errors;

    function new();
      fill    = 0;
      dropped = 0;
      errors  = 0;
    endfunction

    function int unsigned pending();
      return drain_q.size();
    endfunction

    // Buffer one accepted request; on the frame's last face, sort and queue the drain.
    function void note_face(logic [15:0] fref, logic signed [31:0] depth, logic last);
      logic signed [63:0] wide;
      logic [15:0]        r;
      key_t               k;
      drain_rec_t         rec;
      int unsigned        i;
      int unsigned        j;
      if (fill < MAX_FACES) begin
        wide = depth;
        ref_buf[fill] = fref;
        key_buf[fill] = wide[KEY_BITS-1:0];
        fill++;
      end else begin
        dropped = 1'b1;
      end
      if (!last) return;
      // Stable insertion sort, farthest first: only strictly nearer keys move back.
      for (i = 1; i < fill; i++) begin
        r = ref_buf[i];
        k = key_buf[i];
        j = i;
        while (j > 0 && key_buf[j-1] < k) begin
          ref_buf[j] = ref_buf[j-1];
          key_buf[j] = key_buf[j-1];
          j--;
        end
        ref_buf[j] = r;
        key_buf[j] = k;
      end
      for (i = 0; i < fill; i++) begin
        wide         = key_buf[i];
        rec.face_ref = ref_buf[i];
        rec.depth    = wide[31:0];
        rec.eol      = (i + 1 == fill);
        rec.ovf      = dropped;
        drain_q.push_back(rec);
      end
      fill    = 0;
      dropped = 1'b0;
    endfunction

    task report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
      errors++;
      $display("[%0t] MISMATCH %s: expected %h, got %h", $realtime, what, exp_v, got_v);
    endtask

    // Compare one drained result with the oldest expectation.
    task check_face(logic [15:0] got_ref, logic signed [31:0] got_depth,
                    logic got_eol, logic got_ovf);
      drain_rec_t rec;
      if (drain_q.size() == 0) begin
        report_mismatch("result with no face waiting, sorted_ref", 32'h0, 32'(got_ref));
        return;
      end
      rec = drain_q.pop_front();
      if (got_ref !== rec.face_ref)
        report_mismatch("sorted_ref", 32'(rec.face_ref), 32'(got_ref));
      if (got_depth !== rec.depth)
        report_mismatch("sorted_depth", rec.depth, got_depth);
      if (got_eol !== rec.eol)
        report_mismatch("end_of_list", 32'(rec.eol), 32'(got_eol));
      if (got_ovf !== rec.ovf)
        report_mismatch("overflowed", 32'(rec.ovf), 32'(got_ovf));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [15:0]        face_ref_i;
  logic signed [31:0] depth_key_i;
  logic               last_face_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [15:0]        sorted_ref_o;
  logic signed [31:0] sorted_depth_o;
  logic               end_of_list_o;
  logic               overflowed_o;

  depth_order_board board;
  int unsigned      items_sent = 0;
  int unsigned      burst_left = 0;
  int unsigned      cycle_cnt  = 0;
  bit               hold_req   = 1'b0;

  face_depth_sorter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .face_ref_i     (face_ref_i),
    .depth_key_i    (depth_key_i),
    .last_face_i    (last_face_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sorted_ref_o   (sorted_ref_o),
    .sorted_depth_o (sorted_depth_o),
    .end_of_list_o  (end_of_list_o),
    .overflowed_o   (overflowed_o)
  );

  always #5 clk_i = ~clk_i;

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Sample results mid-cycle; the handshake holds until the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1)
      board.check_face(sorted_ref_o, sorted_depth_o, end_of_list_o, overflowed_o);
  end

  // Stall the output side in stretches of differing density; honor long hold-offs.
  initial begin
    int unsigned stretch;
    int unsigned mode;
    stretch = 0;
    mode    = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      if (stretch == 0) begin
        mode    = $urandom_range(0, 2);
        stretch = $urandom_range(5, 60);
      end
      stretch--;
      case (mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Offer one face and hold it until accepted; pace requests in bursts with gaps.
  task automatic offer_face(input logic [15:0] fref, input logic signed [31:0] depth,
                            input logic last);
    int unsigned gap;
    in_valid_i  <= 1'b1;
    face_ref_i  <= fref;
    depth_key_i <= depth;
    last_face_i <= last;
    @(negedge clk_i);
    while (in_ready_o !== 1'b1) @(negedge clk_i);
    @(posedge clk_i);
    board.note_face(fref, depth, last);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
  endtask

  // Send one frame of random faces, last_face on the final one.
  task automatic send_frame(input int unsigned len);
    logic signed [31:0] depth;
    int unsigned        i;
    for (i = 0; i < len; i++) begin
      case ($urandom_range(0, 3))
        0: depth = int'($urandom_range(0, 6)) - 3;
        1: case ($urandom_range(0, 3))
             0:       depth = 32'h8000_0000;
             1:       depth = 32'h7FFF_FFFF;
             2:       depth = 32'h0000_0000;
             default: depth = 32'hFFFF_FFFF;
           endcase
        default: depth = $urandom;
      endcase
      offer_face(16'($urandom_range(0, 65535)), depth, i == len - 1);
    end
  endtask

  // Drop valid and wait until every expected result has drained.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    board = new();
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    face_ref_i  <= '0;
    depth_key_i <= '0;
    last_face_i <= 1'b0;
    burst_left  = 4;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-face frames at the depth extremes.
    offer_face(16'hFFFF, 32'h7FFF_FFFF, 1'b1);
    offer_face(16'h0000, 32'h8000_0000, 1'b1);
    // Mixed frame with ties that must keep arrival order.
    offer_face(16'h0001, 32'sd5, 1'b0);
    offer_face(16'h0002, -32'sd1, 1'b0);
    offer_face(16'h0003, 32'sd5, 1'b0);
    offer_face(16'h0004, 32'h8000_0000, 1'b0);
    offer_face(16'h0005, 32'h7FFF_FFFF, 1'b0);
    offer_face(16'h0006, 32'sd5, 1'b0);
    offer_face(16'h0007, 32'sd0, 1'b0);
    offer_face(16'h0008, -32'sd1, 1'b1);
    // Ascending arrival: full reversal.
    offer_face(16'h0010, 32'sd1, 1'b0);
    offer_face(16'h0011, 32'sd2, 1'b0);
    offer_face(16'h0012, 32'sd3, 1'b1);
    // Alternating bit patterns, tie at the far end.
    offer_face(16'hAAAA, 32'h5555_5555, 1'b0);
    offer_face(16'h5555, 32'hAAAA_AAAA, 1'b0);
    offer_face(16'h8000, 32'h5555_5555, 1'b1);

    // Pause, then hold the output off so a drain backs up into the input.
    wait_drained();
    @(negedge clk_i);
    hold_req = 1'b1;
    @(posedge clk_i);
    send_frame(12);
    send_frame(12);
    wait_drained();

    // Exactly full, then overflowed with the closing face itself dropped.
    send_frame(MAX_FACES);
    send_frame(MAX_FACES + 3);

    while (items_sent < 250) begin
      if ($urandom_range(0, 7) == 0)
        send_frame($urandom_range(MAX_FACES - 4, MAX_FACES + 6));
      else
        send_frame($urandom_range(1, 12));
    end

    wait_drained();
    repeat (MAX_FACES + 16) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
